// File: rtl/prc_pkg.sv
// prc_pkg: shared constants, types and state encoding for the Pareto rank and
// crowding block. Used by the channel interfaces, prc_div and the top module.
package prc_pkg;

  localparam int POP_MAX_DEF = 64;
  localparam int NUM_OBJ_DEF = 3;
  localparam int OBJ_W_DEF   = 32;

  localparam int FIELD_W   = 32;
  localparam int IDX_OUT_W = 6;
  localparam int RANK_W    = 6;
  localparam int CROWD_W   = 24;
  localparam int QUO_W     = 23;

  localparam logic [CROWD_W-1:0] CROWD_BOUNDARY = 24'hFFFFFF;
  localparam logic [CROWD_W-1:0] CROWD_SAT      = 24'hFFFFFE;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOM_PREP,
    S_DOM_SCAN,
    S_DOM_WRITE,
    S_FRONT,
    S_MM_SCAN,
    S_X_FIND,
    S_X_PREP,
    S_X_SCAN,
    S_DIV,
    S_ACC,
    S_DEC_SCAN,
    S_OUT_PREP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/prc_if.sv
// prc_if: valid/ready channel interfaces for population items and result items.
// Depends on prc_pkg for field widths.
interface prc_in_if;
  import prc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] obj_first;
  logic [FIELD_W-1:0] obj_second;
  logic [FIELD_W-1:0] obj_third;
  logic               last_item;
  modport source(output valid, obj_first, obj_second, obj_third, last_item, input ready);
  modport sink(input valid, obj_first, obj_second, obj_third, last_item, output ready);
endinterface

interface prc_out_if;
  import prc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] member_index;
  logic [RANK_W-1:0]    front_rank;
  logic [CROWD_W-1:0]   crowding;
  logic                 last_result;
  modport source(output valid, member_index, front_rank, crowding, last_result, input ready);
  modport sink(input valid, member_index, front_rank, crowding, last_result, output ready);
endinterface

// File: rtl/prc_obj_mem.sv
// prc_obj_mem: objective store, one packed word per individual, one write port
// and two registered read ports. Uses no package items.
module prc_obj_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 96,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [DW-1:0] rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_b
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// File: rtl/prc_div.sv
// prc_div: restoring divider, one quotient bit per cycle, giving
// floor(dividend * 2^(QUO_W-1) / divisor) for dividend <= divisor. Uses prc_pkg.
module prc_div #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       dividend,
  input  logic [W-1:0]       divisor,
  output logic [prc_pkg::QUO_W-1:0] quotient,
  output prc_pkg::div_stat_t status
);
  import prc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [W:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             ge;
  logic [W:0]       rem_sub;

  assign ge      = rem >= {1'b0, divisor};
  assign rem_sub = ge ? (rem - {1'b0, divisor}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rem         <= {1'b0, dividend};
        quotient    <= '0;
        cnt         <= '0;
        status.busy <= 1'b1;
      end else if (status.busy) begin
        // The partial remainder stays below the divisor, so the shift fits.
        quotient <= {quotient[QUO_W-2:0], ge};
        rem      <= {rem_sub[W-1:0], 1'b0};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/pareto_rank_crowding_top.sv
// pareto_rank_crowding_top: non-dominated sorting with crowding distance.
// Depends on prc_pkg, prc_if, prc_obj_mem and prc_div.
//
//   channel   direction  payload                                           item
//   load      in         obj_first, obj_second, obj_third, last_item       one individual
//   report    out        member_index, front_rank, crowding, last_result   one result
//
// Steps: loading takes one item per cycle while the sequencer is idle. After the last
// item the sequencer runs pairwise dominance, then per front and per objective a
// range and neighbor search plus a divide and accumulate for each interior member
// that still takes a term, a pass per front to release dominated members, and
// one output step per result. The objective store read ports and the single
// shared divider pace these steps.
// Reset (rst, synchronous) empties the load; stalls on report simply hold the
// result register and the sequencer.
module pareto_rank_crowding_top #(
  parameter int POPULATION_MAX = prc_pkg::POP_MAX_DEF,
  parameter int NUM_OBJECTIVES = prc_pkg::NUM_OBJ_DEF,
  parameter int OBJ_WIDTH      = prc_pkg::OBJ_W_DEF
) (
  input logic clk,
  input logic rst,
  prc_in_if.sink    load,
  prc_out_if.source report
);
  import prc_pkg::*;

  localparam int IW  = (POPULATION_MAX > 1) ? $clog2(POPULATION_MAX) : 1;
  localparam int CW  = $clog2(POPULATION_MAX + 1);
  localparam int WW  = NUM_OBJECTIVES * OBJ_WIDTH;
  localparam int POP = POPULATION_MAX;

  state_t state, state_next;

  // Load and sequencing registers.
  logic [CW-1:0]     loaded;
  logic [CW-1:0]     loaded_inc;
  logic [CW-1:0]     n;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     sc;
  logic              pv;
  logic [IW-1:0]     pidx;
  logic [1:0]        k;
  logic [RANK_W-1:0] f;
  logic [IW-1:0]     cur_i;

  // Dominance bookkeeping: one counter and flags per individual.
  logic [POP-1:0] row;
  logic [CW-1:0]  cnt [POP];
  logic [POP-1:0] assigned;
  logic [POP-1:0] fmask;
  logic [POP-1:0] fm;

  // Per-front, per-objective crowding state.
  logic [OBJ_WIDTH-1:0] mn, mx, rng;
  logic                 mm_have;
  logic                 hp, hn;
  logic [OBJ_WIDTH-1:0] prv_v, nxt_v;
  logic [IW-1:0]        prv_i, nxt_i;

  // Memories local to this level.
  logic [POP-1:0]     dom_mem [POP];
  logic [POP-1:0]     dom_rd;
  logic [RANK_W-1:0]  rank_mem [POP];
  logic [RANK_W-1:0]  rank_rd;
  logic [CROWD_W-1:0] crowd_mem [POP];
  logic [CROWD_W-1:0] crowd_rd;
  logic               rank_we, crowd_we, dom_we;
  logic [CROWD_W-1:0] crowd_wdata;

  // Objective store and shared divider.
  logic              obj_we;
  logic [WW-1:0]     obj_wdata;
  logic [WW-1:0]     wd_a, wd_b;
  logic              div_start;
  logic [QUO_W-1:0]  quo;
  div_stat_t         div_stat;

  logic                 acc_in;
  logic                 scan_issue, scan_done;
  logic                 out_load;
  logic [OBJ_WIDTH-1:0] va, xb;
  logic                 x_dom_y;
  logic                 y_before;
  logic                 old_bnd;
  logic                 need_div;
  logic [CROWD_W-1:0]   old_eff;
  logic [CROWD_W:0]     acc_sum;

  assign cur_i      = cur[IW-1:0];
  assign acc_in     = load.valid && load.ready;
  assign load.ready = (state == S_IDLE);
  assign loaded_inc = (loaded < CW'(POP)) ? loaded + 1'b1 : loaded;
  assign scan_issue = sc < n;
  assign scan_done  = !scan_issue && !pv;
  assign out_load   = (state == S_OUT) && (!report.valid || report.ready);

  // Individuals beyond the store depth are dropped, only the low bits are kept.
  always_comb begin
    obj_wdata = '0;
    obj_wdata[OBJ_WIDTH-1:0] = load.obj_first[OBJ_WIDTH-1:0];
    obj_wdata[OBJ_WIDTH +: OBJ_WIDTH] = load.obj_second[OBJ_WIDTH-1:0];
    if (NUM_OBJECTIVES > 2) begin
      obj_wdata[WW-1 -: OBJ_WIDTH] = load.obj_third[OBJ_WIDTH-1:0];
    end
  end
  assign obj_we = acc_in && (loaded < CW'(POP));

  prc_obj_mem #(
    .DEPTH(POP),
    .DW   (WW)
  ) u_obj_mem (
    .clk    (clk),
    .we     (obj_we),
    .waddr  (loaded[IW-1:0]),
    .wdata  (obj_wdata),
    .raddr_a(sc[IW-1:0]),
    .rdata_a(wd_a),
    .raddr_b(cur_i),
    .rdata_b(wd_b)
  );

  // Port A carries the scanned individual, port B the one being worked on.
  assign va  = wd_a[int'(k) * OBJ_WIDTH +: OBJ_WIDTH];
  assign xb  = wd_b[int'(k) * OBJ_WIDTH +: OBJ_WIDTH];
  assign rng = mx - mn;

  always_comb begin
    logic le_all, lt_any;
    le_all = 1'b1;
    lt_any = 1'b0;
    for (int o = 0; o < NUM_OBJECTIVES; o++) begin
      le_all = le_all && (wd_b[o * OBJ_WIDTH +: OBJ_WIDTH] <= wd_a[o * OBJ_WIDTH +: OBJ_WIDTH]);
      lt_any = lt_any || (wd_b[o * OBJ_WIDTH +: OBJ_WIDTH] < wd_a[o * OBJ_WIDTH +: OBJ_WIDTH]);
    end
    x_dom_y = le_all && lt_any;
  end

  // The scanned individual comes earlier in the order of this objective when
  // its value is lower, or equal with a lower index.
  assign y_before = (va < xb) || ((va == xb) && (CW'(pidx) < cur));

  always_comb begin
    for (int j = 0; j < POP; j++) begin
      fm[j] = (CW'(j) < n) && !assigned[j] && (cnt[j] == '0);
    end
  end

  // On the first objective the crowding value starts from zero.
  assign old_eff  = (k == 2'd0) ? '0 : crowd_rd;
  assign old_bnd  = (old_eff == CROWD_BOUNDARY);
  assign need_div = hp && hn && (rng != '0) && !old_bnd;
  assign acc_sum  = {1'b0, old_eff} + (CROWD_W + 1)'(quo);

  assign div_start = (state == S_X_SCAN) && scan_done && need_div;

  prc_div #(
    .W(OBJ_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(nxt_v - prv_v),
    .divisor (rng),
    .quotient(quo),
    .status  (div_stat)
  );

  // Crowding write: ends get the boundary code, a zero range or a member that
  // already holds the boundary keeps its value, others take the saturated sum.
  always_comb begin
    crowd_we    = 1'b0;
    crowd_wdata = old_eff;
    if (state == S_X_SCAN && scan_done && !need_div) begin
      crowd_we    = 1'b1;
      crowd_wdata = (!hp || !hn) ? CROWD_BOUNDARY : old_eff;
    end else if (state == S_ACC) begin
      crowd_we    = 1'b1;
      crowd_wdata = (acc_sum > {1'b0, CROWD_SAT}) ? CROWD_SAT : acc_sum[CROWD_W-1:0];
    end
  end

  assign rank_we = (state == S_X_FIND) && (cur != n) && fmask[cur_i] && (k == 2'd0);
  assign dom_we  = (state == S_DOM_WRITE);

  always_ff @(posedge clk) begin
    if (dom_we) begin
      dom_mem[cur_i] <= row;
    end
    dom_rd <= dom_mem[sc[IW-1:0]];
    if (rank_we) begin
      rank_mem[cur_i] <= f;
    end
    rank_rd <= rank_mem[cur_i];
    if (crowd_we) begin
      crowd_mem[cur_i] <= crowd_wdata;
    end
    crowd_rd <= crowd_mem[cur_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc_in && load.last_item) state_next = S_DOM_PREP;
      end
      S_DOM_PREP: state_next = S_DOM_SCAN;
      S_DOM_SCAN: begin
        if (scan_done) state_next = S_DOM_WRITE;
      end
      S_DOM_WRITE: begin
        state_next = (cur + 1'b1 == n) ? S_FRONT : S_DOM_PREP;
      end
      S_FRONT: begin
        state_next = (fm == '0) ? S_OUT_PREP : S_MM_SCAN;
      end
      S_MM_SCAN: begin
        if (scan_done) state_next = S_X_FIND;
      end
      S_X_FIND: begin
        if (cur == n) begin
          state_next = (k == 2'(NUM_OBJECTIVES - 1)) ? S_DEC_SCAN : S_MM_SCAN;
        end else if (fmask[cur_i]) begin
          state_next = S_X_PREP;
        end
      end
      S_X_PREP: state_next = S_X_SCAN;
      S_X_SCAN: begin
        if (scan_done) state_next = need_div ? S_DIV : S_X_FIND;
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_ACC;
      end
      S_ACC: state_next = S_X_FIND;
      S_DEC_SCAN: begin
        if (scan_done) state_next = S_FRONT;
      end
      S_OUT_PREP: state_next = S_OUT;
      S_OUT: begin
        if (out_load) state_next = (cur + 1'b1 == n) ? S_IDLE : S_OUT_PREP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers that need a known value after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded       <= '0;
      pv           <= 1'b0;
      report.valid <= 1'b0;
    end else begin
      if (acc_in) begin
        loaded <= load.last_item ? '0 : loaded_inc;
      end
      if (state == S_DOM_SCAN || state == S_MM_SCAN || state == S_X_SCAN ||
          state == S_DEC_SCAN) begin
        pv <= scan_issue;
      end else begin
        pv <= 1'b0;
      end
      if (out_load) begin
        report.valid <= 1'b1;
      end else if (report.ready) begin
        report.valid <= 1'b0;
      end
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (state == S_DOM_SCAN || state == S_MM_SCAN || state == S_X_SCAN ||
        state == S_DEC_SCAN) begin
      if (scan_issue) begin
        sc   <= sc + 1'b1;
        pidx <= sc[IW-1:0];
      end
    end
    case (state)
      S_IDLE: begin
        if (acc_in && load.last_item) begin
          n        <= loaded_inc;
          cur      <= '0;
          assigned <= '0;
          f        <= '0;
          for (int j = 0; j < POP; j++) cnt[j] <= '0;
        end
      end
      S_DOM_PREP: begin
        row <= '0;
        sc  <= '0;
      end
      S_DOM_SCAN: begin
        if (pv && x_dom_y) begin
          for (int j = 0; j < POP; j++) begin
            if (pidx == IW'(j)) begin
              row[j] <= 1'b1;
              cnt[j] <= cnt[j] + 1'b1;
            end
          end
        end
      end
      S_DOM_WRITE: cur <= cur + 1'b1;
      S_FRONT: begin
        fmask    <= fm;
        assigned <= assigned | fm;
        k        <= '0;
        sc       <= '0;
        mm_have  <= 1'b0;
        cur      <= '0;
      end
      S_MM_SCAN: begin
        if (pv && fmask[pidx]) begin
          if (!mm_have || va < mn) mn <= va;
          if (!mm_have || va > mx) mx <= va;
          mm_have <= 1'b1;
        end
        if (scan_done) cur <= '0;
      end
      S_X_FIND: begin
        if (cur == n) begin
          k       <= k + 1'b1;
          sc      <= '0;
          mm_have <= 1'b0;
        end else if (!fmask[cur_i]) begin
          cur <= cur + 1'b1;
        end
      end
      S_X_PREP: begin
        hp <= 1'b0;
        hn <= 1'b0;
        sc <= '0;
      end
      S_X_SCAN: begin
        if (pv && fmask[pidx] && (CW'(pidx) != cur)) begin
          if (y_before) begin
            if (!hp || va > prv_v || (va == prv_v && pidx > prv_i)) begin
              hp    <= 1'b1;
              prv_v <= va;
              prv_i <= pidx;
            end
          end else begin
            if (!hn || va < nxt_v || (va == nxt_v && pidx < nxt_i)) begin
              hn    <= 1'b1;
              nxt_v <= va;
              nxt_i <= pidx;
            end
          end
        end
        if (scan_done && !need_div) cur <= cur + 1'b1;
      end
      S_ACC: cur <= cur + 1'b1;
      S_DEC_SCAN: begin
        if (pv && fmask[pidx]) begin
          for (int j = 0; j < POP; j++) begin
            if (dom_rd[j] && cnt[j] != '0) cnt[j] <= cnt[j] - 1'b1;
          end
        end
        if (scan_done) f <= f + 1'b1;
      end
      S_OUT: begin
        if (out_load) begin
          report.member_index <= IDX_OUT_W'(cur_i);
          report.front_rank   <= rank_rd;
          report.crowding     <= crowd_rd;
          report.last_result  <= (cur + 1'b1 == n);
          cur                 <= cur + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The load count never passes the store depth.
  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(POP))
    else $error("load count beyond store depth");

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == S_DIV)
    else $error("divider busy outside divide state");

  // A last item starts evaluation at once.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (acc_in && load.last_item) |=> state == S_DOM_PREP)
    else $error("evaluation did not start");

  // Members of the current front are always marked as ranked.
  a_front_assigned: assert property (@(posedge clk) disable iff (rst)
    (state == S_X_FIND || state == S_DEC_SCAN) |-> (fmask & ~assigned) == '0)
    else $error("front member not marked ranked");
endmodule
